@@ rtl/core/touch_sample_filter_calibrator_defines.svh @@
// Assertion macros for the touch sample filter and calibrator.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef TOUCH_SAMPLE_FILTER_CALIBRATOR_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_CALIBRATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSFC_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tsfc_pkg.sv @@
// Shared types and constants of the touch sample filter and calibrator.
// No dependencies; imported by every module of the block.
package tsfc_pkg;

    localparam int NUM_SAMPLES = 5;
    localparam int SAMPLE_W    = 12;
    localparam int RANK_W      = 3;
    localparam int SUM_W       = 14;
    localparam int FRAC_W      = 8;
    localparam int SCALE_W     = 2 * SAMPLE_W;
    localparam int DIV_W       = SCALE_W + FRAC_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);
    localparam int GAIN_W      = 9;
    localparam int SMOOTH_X_W  = 17;
    localparam int SMOOTH_Y_W  = 16;
    localparam int POS_X_W     = 9;
    localparam int POS_Y_W     = 8;
    localparam int PRESS_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;

    // Mean of the three middle samples: floor(sum / 3) == (sum * 43691) >> 17
    // for every sum below 2^17.
    localparam int MEAN_RECIP_W = 17;
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = 17'd43691;
    localparam int MEAN_SHIFT   = 17;

    localparam int PGAIN_W = 7;
    localparam logic [PGAIN_W-1:0] PRESSURE_GAIN = 7'd100;
    localparam int PRESS_SHIFT = 12;

    localparam logic [SMOOTH_X_W-1:0] SMOOTH_X_MAX = '1;
    localparam logic [SMOOTH_Y_W-1:0] SMOOTH_Y_MAX = '1;
    localparam logic [PRESS_W-1:0]    PRESS_MAX    = '1;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Channel codes carried with each request.
    localparam logic [1:0] CH_X  = 2'd0;
    localparam logic [1:0] CH_Y  = 2'd1;
    localparam logic [1:0] CH_Z1 = 2'd2;
    localparam logic [1:0] CH_Z2 = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_HIGH   = 3'd7;

    // Reset values of the registers.
    localparam sample_t            RST_X_MIN        = 12'd150;
    localparam sample_t            RST_X_MAX        = 12'd1900;
    localparam sample_t            RST_Y_MIN        = 12'd120;
    localparam sample_t            RST_Y_MAX        = 12'd1900;
    localparam logic [GAIN_W-1:0]  RST_SMOOTH_GAIN  = 9'd128;
    localparam sample_t            RST_SPREAD_LIMIT = 12'd32;
    localparam sample_t            RST_VALID_LOW    = 12'd32;
    localparam sample_t            RST_VALID_HIGH   = 12'd2015;

    localparam logic [1:0] TOUCH_TOP = 2'd3;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              reject;
    } lane_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK,
        ST_MEAN,
        ST_CHECK,
        ST_BOUNDS,
        ST_PREP,
        ST_DLOAD,
        ST_DWAIT,
        ST_SDIFF,
        ST_SMUL,
        ST_SFIN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        JOB_X,
        JOB_Y,
        JOB_P
    } job_t;

    typedef struct packed {
        logic div_start;
        logic res_load;
        logic in_ready;
    } ctl_t;

endpackage

@@ rtl/core/tsfc_lane.sv @@
// One sample lane: rank of its sample among the five and the reject test
// against the trimmed mean and the valid window. Depends on tsfc_pkg.
module tsfc_lane
    import tsfc_pkg::*;
(
    input  sample_t                        own,
    input  sample_t [NUM_SAMPLES-1:0]      samples,
    input  logic    [NUM_SAMPLES-1:0]      lower_mask,
    input  sample_t                        mean,
    input  sample_t                        spread_limit,
    input  sample_t                        valid_low,
    input  sample_t                        valid_high,
    output lane_res_t                      res
);

    logic [RANK_W-1:0] rank;
    sample_t           dev;

    // Equal samples are ordered by lane number so that every rank is unique.
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < NUM_SAMPLES; j++)
        begin
            if ((samples[j] < own) || (lower_mask[j] && (samples[j] == own)))
            begin
                rank = rank + RANK_W'(1);
            end
        end
    end

    assign dev = (own > mean) ? (own - mean) : (mean - own);

    assign res.rank   = rank;
    assign res.reject = (dev > spread_limit) || (own < valid_low) || (own > valid_high);

endmodule

@@ rtl/core/tsfc_merge.sv @@
// Merging stage of the sample lanes: sum of the three middle-ranked samples
// and the combined reject flag. Depends on tsfc_pkg.
module tsfc_merge
    import tsfc_pkg::*;
(
    input  sample_t   [NUM_SAMPLES-1:0] samples,
    input  lane_res_t [NUM_SAMPLES-1:0] lanes,
    output logic      [SUM_W-1:0]       mid_sum,
    output logic                        reject
);

    always_comb
    begin
        mid_sum = '0;
        reject  = 1'b0;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            if ((lanes[i].rank != '0) && (lanes[i].rank != RANK_W'(NUM_SAMPLES - 1)))
            begin
                mid_sum = mid_sum + SUM_W'(samples[i]);
            end
            reject = reject | lanes[i].reject;
        end
    end

endmodule

@@ rtl/core/tsfc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the axis scaling
// and the pressure calculation. Depends on tsfc_pkg.
module tsfc_div
    import tsfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  sample_t          den,
    output div_stat_t        stat,
    output logic [DIV_W-1:0] quot
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] quot_reg;
    sample_t          den_reg;
    sample_t          rem_reg;

    logic [SAMPLE_W:0] partial;
    logic              fits;
    sample_t           rem_next;

    assign partial  = {rem_reg, num_reg[DIV_W-1]};
    assign fits     = partial >= {1'b0, den_reg};
    assign rem_next = fits ? SAMPLE_W'(partial - {1'b0, den_reg}) : partial[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

@@ rtl/core/touch_sample_filter_calibrator.sv @@
// Resistive touch filter and calibrator. Each request carries either a pen-up
// event or five 12-bit samples of one channel (x, y, z1, z2); five lanes rank
// and check the samples, a merging stage sums the middle three for the trimmed
// mean. A z2 request ends a scan; when x and y are both nonzero the single
// serial divider (one bit per cycle, 32 bits) runs three times, for the x scale,
// the y scale and the pressure. Results leave through an output register, so a
// waiting result does not block the next request until the next result is ready.
// Configuration writes take effect at once and should only be made while no
// request is in flight.
`include "touch_sample_filter_calibrator_defines.svh"

module touch_sample_filter_calibrator
    import tsfc_pkg::*;
#(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_a, sample_b, sample_c,
                                                 // sample_d, sample_e, zero pad
    input  logic [2:0]            s_axis_tuser,  // pen_down, cmd
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pos_x, pos_y, pressure,
                                                 // touch_state, zero pad
    output logic [1:0]            m_axis_tuser   // report, report_pressed
);

    localparam int TX_W = $clog2(SCREEN_W * 256 + 1);
    localparam int TY_W = $clog2(SCREEN_H * 256 + 1);
    localparam int DX_W = ((TX_W > SMOOTH_X_W) ? TX_W : SMOOTH_X_W) + 1;
    localparam int DY_W = ((TY_W > SMOOTH_Y_W) ? TY_W : SMOOTH_Y_W) + 1;
    localparam int PX_W = DX_W + GAIN_W + 1;
    localparam int PY_W = DY_W + GAIN_W + 1;
    localparam sample_t SCR_W12 = SAMPLE_W'(SCREEN_W);
    localparam sample_t SCR_H12 = SAMPLE_W'(SCREEN_H);

    state_t state_reg, state_next;
    ctl_t   ctl;

    // Configuration and persistent state.
    logic [GAIN_W-1:0]     smooth_gain_reg;
    sample_t               spread_limit_reg;
    sample_t               valid_low_reg;
    sample_t               valid_high_reg;
    sample_t               bound_reg [4];
    sample_t               channel_value_reg [4];
    logic [SMOOTH_X_W-1:0] smooth_x_reg;
    logic [SMOOTH_Y_W-1:0] smooth_y_reg;
    logic [POS_X_W-1:0]    last_x_reg;
    logic [POS_Y_W-1:0]    last_y_reg;
    logic [1:0]            touch_reg;
    job_t                  job_reg;
    logic                  m_valid_reg;

    // Per-request working registers.
    sample_t [NUM_SAMPLES-1:0] sample_reg;
    logic                      pen_reg;
    logic [1:0]                cmd_reg;
    logic [SUM_W-1:0]          sum_reg;
    sample_t                   mean_reg;
    logic [SCALE_W-1:0]        pmul_reg;
    logic                      p_sat_reg;
    logic                      p_zero_reg;
    logic [DIV_W-1:0]          num_x_reg;
    logic [DIV_W-1:0]          num_y_reg;
    logic [DIV_W-1:0]          num_p_reg;
    sample_t                   den_x_reg;
    sample_t                   den_y_reg;
    logic                      zero_x_reg;
    logic                      zero_y_reg;
    logic [TX_W-1:0]           tgt_x_reg;
    logic [TY_W-1:0]           tgt_y_reg;
    logic [PRESS_W-1:0]        pres_reg;
    logic signed [DX_W-1:0]    dx_reg;
    logic signed [DY_W-1:0]    dy_reg;
    logic signed [PX_W-1:0]    px_reg;
    logic signed [PY_W-1:0]    py_reg;
    logic [POS_X_W-1:0]        res_pos_x_reg;
    logic [POS_Y_W-1:0]        res_pos_y_reg;
    logic [PRESS_W-1:0]        res_pres_reg;
    logic [1:0]                res_touch_reg;
    logic                      res_report_reg;
    logic                      res_pressed_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;
    logic [1:0]                m_user_reg;

    // Lanes and merge.
    sample_t   [NUM_SAMPLES-1:0] in_samples;
    lane_res_t [NUM_SAMPLES-1:0] lane_res;
    logic      [SUM_W-1:0]       mid_sum;
    logic                        any_reject;

    for (genvar i = 0; i < NUM_SAMPLES; i++)
    begin : g_lane
        localparam logic [NUM_SAMPLES-1:0] LOW_MASK = NUM_SAMPLES'((1 << i) - 1);

        assign in_samples[i] = s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];

        tsfc_lane u_lane (
            .own          (sample_reg[i]),
            .samples      (sample_reg),
            .lower_mask   (LOW_MASK),
            .mean         (mean_reg),
            .spread_limit (spread_limit_reg),
            .valid_low    (valid_low_reg),
            .valid_high   (valid_high_reg),
            .res          (lane_res[i])
        );
    end

    tsfc_merge u_merge (
        .samples (sample_reg),
        .lanes   (lane_res),
        .mid_sum (mid_sum),
        .reject  (any_reject)
    );

    // Shared divider.
    logic [DIV_W-1:0] div_num;
    sample_t          div_den;
    div_stat_t        div_stat;
    logic [DIV_W-1:0] div_quot;

    always_comb
    begin
        case (job_reg)
            JOB_X:
            begin
                div_num = num_x_reg;
                div_den = den_x_reg;
            end
            JOB_Y:
            begin
                div_num = num_y_reg;
                div_den = den_y_reg;
            end
            default:
            begin
                div_num = num_p_reg;
                div_den = channel_value_reg[CH_Z1];
            end
        endcase
    end

    tsfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Datapath terms.
    logic [MEAN_RECIP_W+SUM_W-1:0] mean_prod;
    sample_t                       xr;
    sample_t                       yr;
    logic                          scan_ok;
    logic [SCALE_W-1:0]            scale_x;
    logic [SCALE_W-1:0]            scale_y;
    logic [SCALE_W+PGAIN_W-1:0]    pgain_prod;
    logic signed [DX_W-1:0]        dx_next;
    logic signed [DY_W-1:0]        dy_next;
    logic signed [PX_W-1:0]        px_next;
    logic signed [PY_W-1:0]        py_next;
    logic signed [PX_W-1:0]        rx;
    logic signed [PY_W-1:0]        ry;
    logic [SMOOTH_X_W-1:0]         smooth_x_next;
    logic [SMOOTH_Y_W-1:0]         smooth_y_next;
    logic                          follow;

    assign mean_prod  = (MEAN_RECIP_W+SUM_W)'(sum_reg) * (MEAN_RECIP_W+SUM_W)'(MEAN_RECIP);
    assign xr         = channel_value_reg[CH_X];
    assign yr         = channel_value_reg[CH_Y];
    assign scan_ok    = (xr != '0) && (yr != '0);
    assign scale_x    = SCALE_W'(SCR_W12) * SCALE_W'(bound_reg[1] - xr);
    assign scale_y    = SCALE_W'(SCR_H12) * SCALE_W'(bound_reg[3] - yr);
    assign pgain_prod = (SCALE_W+PGAIN_W)'(pmul_reg) * (SCALE_W+PGAIN_W)'(PRESSURE_GAIN);

    assign dx_next = $signed(DX_W'(tgt_x_reg)) - $signed(DX_W'(smooth_x_reg));
    assign dy_next = $signed(DY_W'(tgt_y_reg)) - $signed(DY_W'(smooth_y_reg));
    assign px_next = dx_reg * $signed({1'b0, smooth_gain_reg});
    assign py_next = dy_reg * $signed({1'b0, smooth_gain_reg});
    // Arithmetic shift gives the floor of the scaled step for both signs.
    assign rx = $signed(PX_W'(smooth_x_reg)) + (px_reg >>> FRAC_W);
    assign ry = $signed(PY_W'(smooth_y_reg)) + (py_reg >>> FRAC_W);
    assign follow = (touch_reg == TOUCH_TOP);

    always_comb
    begin
        if (!follow)
        begin
            if (DX_W'(tgt_x_reg) > DX_W'(SMOOTH_X_MAX))
                smooth_x_next = SMOOTH_X_MAX;
            else
                smooth_x_next = SMOOTH_X_W'(tgt_x_reg);
        end
        else if (rx < 0)
            smooth_x_next = '0;
        else if (rx > $signed(PX_W'(SMOOTH_X_MAX)))
            smooth_x_next = SMOOTH_X_MAX;
        else
            smooth_x_next = rx[SMOOTH_X_W-1:0];
    end

    always_comb
    begin
        if (!follow)
        begin
            if (DY_W'(tgt_y_reg) > DY_W'(SMOOTH_Y_MAX))
                smooth_y_next = SMOOTH_Y_MAX;
            else
                smooth_y_next = SMOOTH_Y_W'(tgt_y_reg);
        end
        else if (ry < 0)
            smooth_y_next = '0;
        else if (ry > $signed(PY_W'(SMOOTH_Y_MAX)))
            smooth_y_next = SMOOTH_Y_MAX;
        else
            smooth_y_next = ry[SMOOTH_Y_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_RANK;
            ST_RANK:
                state_next = pen_reg ? ST_MEAN : ST_EMIT;
            ST_MEAN:
                state_next = ST_CHECK;
            ST_CHECK:
                state_next = (cmd_reg == CH_Z2) ? ST_BOUNDS : ST_IDLE;
            ST_BOUNDS:
                state_next = scan_ok ? ST_PREP : ST_EMIT;
            ST_PREP:
                state_next = ST_DLOAD;
            ST_DLOAD:
                state_next = ST_DWAIT;
            ST_DWAIT:
                if (div_stat.done)
                    state_next = (job_reg == JOB_P) ? ST_SDIFF : ST_DLOAD;
            ST_SDIFF:
                state_next = ST_SMUL;
            ST_SMUL:
                state_next = ST_SFIN;
            ST_SFIN:
                state_next = ST_EMIT;
            ST_EMIT:
                if (!m_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        ctl.in_ready  = 1'b0;
        ctl.div_start = 1'b0;
        ctl.res_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  ctl.in_ready  = 1'b1;
            ST_DLOAD: ctl.div_start = 1'b1;
            ST_EMIT:  ctl.res_load  = !m_valid_reg || m_axis_tready;
            default:  ctl.in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_gain_reg  <= RST_SMOOTH_GAIN;
            spread_limit_reg <= RST_SPREAD_LIMIT;
            valid_low_reg    <= RST_VALID_LOW;
            valid_high_reg   <= RST_VALID_HIGH;
            bound_reg[0]     <= RST_X_MIN;
            bound_reg[1]     <= RST_X_MAX;
            bound_reg[2]     <= RST_Y_MIN;
            bound_reg[3]     <= RST_Y_MAX;
            for (int k = 0; k < 4; k++)
            begin
                channel_value_reg[k] <= '0;
            end
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            touch_reg    <= '0;
            job_reg      <= JOB_X;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_RANK && !pen_reg)
            begin
                touch_reg <= '0;
            end

            if (state_reg == ST_CHECK)
            begin
                channel_value_reg[cmd_reg] <= any_reject ? '0 : mean_reg;
            end

            // Widen the calibration bounds to take in the new point.
            if (state_reg == ST_BOUNDS && scan_ok)
            begin
                if (xr < bound_reg[0]) bound_reg[0] <= xr;
                if (xr > bound_reg[1]) bound_reg[1] <= xr;
                if (yr < bound_reg[2]) bound_reg[2] <= yr;
                if (yr > bound_reg[3]) bound_reg[3] <= yr;
            end

            if (state_reg == ST_PREP)
            begin
                job_reg <= JOB_X;
            end

            if (state_reg == ST_DWAIT && div_stat.done)
            begin
                case (job_reg)
                    JOB_X:   job_reg <= JOB_Y;
                    JOB_Y:   job_reg <= JOB_P;
                    default: job_reg <= JOB_X;
                endcase
            end

            if (state_reg == ST_SFIN)
            begin
                smooth_x_reg <= smooth_x_next;
                smooth_y_reg <= smooth_y_next;
                last_x_reg   <= smooth_x_next[SMOOTH_X_W-1 -: POS_X_W];
                last_y_reg   <= smooth_y_next[SMOOTH_Y_W-1 -: POS_Y_W];
                if (!follow)
                begin
                    touch_reg <= touch_reg + 2'd1;
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_X_MIN:        bound_reg[0]     <= cfg_data;
                    REG_X_MAX:        bound_reg[1]     <= cfg_data;
                    REG_Y_MIN:        bound_reg[2]     <= cfg_data;
                    REG_Y_MAX:        bound_reg[3]     <= cfg_data;
                    REG_SMOOTH_GAIN:  smooth_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_SPREAD_LIMIT: spread_limit_reg <= cfg_data;
                    REG_VALID_LOW:    valid_low_reg    <= cfg_data;
                    REG_VALID_HIGH:   valid_high_reg   <= cfg_data;
                    default:          valid_high_reg   <= valid_high_reg;
                endcase
            end

            if (ctl.res_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sample_reg <= in_samples;
                    pen_reg    <= s_axis_tuser[0];
                    cmd_reg    <= s_axis_tuser[2:1];
                end
            end
            ST_RANK:
            begin
                sum_reg         <= mid_sum;
                res_pos_x_reg   <= last_x_reg;
                res_pos_y_reg   <= last_y_reg;
                res_pres_reg    <= '0;
                res_touch_reg   <= '0;
                res_report_reg  <= (touch_reg != '0);
                res_pressed_reg <= 1'b0;
            end
            ST_MEAN:
            begin
                mean_reg <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
            end
            ST_BOUNDS:
            begin
                pmul_reg <= SCALE_W'(xr) *
                            SCALE_W'(channel_value_reg[CH_Z2] - channel_value_reg[CH_Z1]);
                p_sat_reg  <= (channel_value_reg[CH_Z1] == '0);
                p_zero_reg <= (channel_value_reg[CH_Z2] <= channel_value_reg[CH_Z1]);
                res_pos_x_reg   <= last_x_reg;
                res_pos_y_reg   <= last_y_reg;
                res_pres_reg    <= '0;
                res_touch_reg   <= touch_reg;
                res_report_reg  <= 1'b0;
                res_pressed_reg <= 1'b0;
            end
            ST_PREP:
            begin
                num_x_reg  <= {scale_x, FRAC_W'(0)};
                num_y_reg  <= {scale_y, FRAC_W'(0)};
                den_x_reg  <= bound_reg[1] - bound_reg[0];
                den_y_reg  <= bound_reg[3] - bound_reg[2];
                zero_x_reg <= (bound_reg[1] <= bound_reg[0]) || (xr > bound_reg[1]);
                zero_y_reg <= (bound_reg[3] <= bound_reg[2]) || (yr > bound_reg[3]);
                // Dividing by 4096 first leaves the floor of the full quotient unchanged.
                num_p_reg  <= DIV_W'(pgain_prod[SCALE_W+PGAIN_W-1:PRESS_SHIFT]);
            end
            ST_DWAIT:
            begin
                if (div_stat.done)
                begin
                    case (job_reg)
                        JOB_X:
                            tgt_x_reg <= zero_x_reg ? '0 : div_quot[TX_W-1:0];
                        JOB_Y:
                            tgt_y_reg <= zero_y_reg ? '0 : div_quot[TY_W-1:0];
                        default:
                        begin
                            if (p_sat_reg)
                                pres_reg <= PRESS_MAX;
                            else if (p_zero_reg)
                                pres_reg <= '0;
                            else if (|div_quot[DIV_W-1:PRESS_W])
                                pres_reg <= PRESS_MAX;
                            else
                                pres_reg <= div_quot[PRESS_W-1:0];
                        end
                    endcase
                end
            end
            ST_SDIFF:
            begin
                dx_reg <= dx_next;
                dy_reg <= dy_next;
            end
            ST_SMUL:
            begin
                px_reg <= px_next;
                py_reg <= py_next;
            end
            ST_SFIN:
            begin
                res_pos_x_reg   <= smooth_x_next[SMOOTH_X_W-1 -: POS_X_W];
                res_pos_y_reg   <= smooth_y_next[SMOOTH_Y_W-1 -: POS_Y_W];
                res_pres_reg    <= pres_reg;
                res_touch_reg   <= follow ? touch_reg : touch_reg + 2'd1;
                res_report_reg  <= follow;
                res_pressed_reg <= follow;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase

        if (ctl.res_load)
        begin
            m_data_reg <= {5'd0, res_touch_reg, res_pres_reg, res_pos_y_reg, res_pos_x_reg};
            m_user_reg <= {res_pressed_reg, res_report_reg};
        end
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `TSFC_ASSERT_HOLDS(a_pressed_needs_report, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tuser[0] && (m_axis_tdata[34:33] == TOUCH_TOP),
        "pressed report without report at top touch state")
    `TSFC_ASSERT_HOLDS(a_div_start_idle, ctl.div_start, !div_stat.busy,
        "divider started while still busy")
    `TSFC_ASSERT_NEXT(a_one_request_at_a_time, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second request taken before the first finished")

endmodule

@@ verif/touch_report_checker.sv @@
// Result checker for the touch sample filter and calibrator: follows register
// writes and accepted requests, predicts each cursor result and compares it.
// Depends on tsfc_pkg for widths, channel codes and register indexes.
`timescale 1ns / 1ps

module touch_report_checker
    import tsfc_pkg::*;
#(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_a, sample_b, sample_c,
                                                 // sample_d, sample_e, zero pad
    input  logic [2:0]            s_axis_tuser,  // pen_down, cmd
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // pos_x, pos_y, pressure,
                                                 // touch_state, zero pad
    input  logic [1:0]            m_axis_tuser,  // report, report_pressed
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    reports_seen,
    output int                    pressed_seen
);

    typedef struct packed {
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [PRESS_W-1:0] pressure;
        logic [1:0]         touch_state;
        logic               report;
        logic               report_pressed;
    } cursor_t;

    logic [GAIN_W-1:0]     gain;
    sample_t               spread_lim;
    sample_t               win_lo;
    sample_t               win_hi;
    sample_t               cal_x_lo;
    sample_t               cal_x_hi;
    sample_t               cal_y_lo;
    sample_t               cal_y_hi;
    sample_t               chan_mean [4];
    logic [SMOOTH_X_W-1:0] filt_x;
    logic [SMOOTH_Y_W-1:0] filt_y;
    logic [POS_X_W-1:0]    shown_x;
    logic [POS_Y_W-1:0]    shown_y;
    logic [1:0]            touch_level;
    cursor_t               expected_cursors [$];

    task automatic restore_defaults();
        gain        = RST_SMOOTH_GAIN;
        spread_lim  = RST_SPREAD_LIMIT;
        win_lo      = RST_VALID_LOW;
        win_hi      = RST_VALID_HIGH;
        cal_x_lo    = RST_X_MIN;
        cal_x_hi    = RST_X_MAX;
        cal_y_lo    = RST_Y_MIN;
        cal_y_hi    = RST_Y_MAX;
        chan_mean   = '{default: '0};
        filt_x      = '0;
        filt_y      = '0;
        shown_x     = '0;
        shown_y     = '0;
        touch_level = '0;
        expected_cursors.delete();
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        reports_seen = 0;
        pressed_seen = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_X_MIN:        cal_x_lo   = value;
            REG_X_MAX:        cal_x_hi   = value;
            REG_Y_MIN:        cal_y_lo   = value;
            REG_Y_MAX:        cal_y_hi   = value;
            REG_SMOOTH_GAIN:  gain       = value[GAIN_W-1:0];
            REG_SPREAD_LIMIT: spread_lim = value;
            REG_VALID_LOW:    win_lo     = value;
            REG_VALID_HIGH:   win_hi     = value;
            default: ;
        endcase
    endtask

    // Sorts the five samples, averages the middle three and rejects the
    // channel if any sample strays too far or leaves the valid window.
    function automatic sample_t trimmed_mean(input logic [59:0] raw);
        sample_t v [5];
        sample_t t;
        int      mean;
        int      offset;
        for (int i = 0; i < 5; i++)
            v[i] = raw[12*i +: 12];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4 - i; j++)
                if (v[j] > v[j+1])
                begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
        mean = (int'(v[1]) + int'(v[2]) + int'(v[3])) / 3;
        for (int i = 0; i < 5; i++)
        begin
            offset = (int'(v[i]) > mean) ? int'(v[i]) - mean : mean - int'(v[i]);
            if (offset > int'(spread_lim))
                return '0;
        end
        for (int i = 0; i < 5; i++)
            if (v[i] < win_lo || v[i] > win_hi)
                return '0;
        return sample_t'(mean);
    endfunction

    function automatic longint axis_target(input int lo, input int hi, input int raw,
                                           input int size);
        if (hi <= lo || raw > hi)
            return 0;
        return (longint'(size) * 256 * longint'(hi - raw)) / longint'(hi - lo);
    endfunction

    // Moves the filtered position towards the target by gain/256 of the gap,
    // rounding towards minus infinity; before the touch settles it jumps.
    function automatic longint eased(input longint s, input longint t, input longint maxv,
                                     input bit follow);
        longint d;
        longint p;
        longint q;
        longint r;
        if (!follow)
            return (t > maxv) ? maxv : t;
        d = t - s;
        p = d * longint'(gain);
        q = (p >= 0) ? p / 256 : -((-p + 255) / 256);
        r = s + q;
        if (r < 0)
            r = 0;
        if (r > maxv)
            r = maxv;
        return r;
    endfunction

    function automatic int pressure_est(input int x, input int z1, input int z2);
        longint p;
        if (z1 == 0)
            return int'(PRESS_MAX);
        if (z2 <= z1)
            return 0;
        p = (100 * longint'(x) * longint'(z2 - z1)) / (4096 * longint'(z1));
        return (p > longint'(PRESS_MAX)) ? int'(PRESS_MAX) : int'(p);
    endfunction

    task automatic predict_request(input logic pen, input logic [1:0] ch,
                                   input logic [59:0] raw);
        cursor_t r;
        bit      follow;
        int      xr;
        int      yr;
        r = '0;
        if (!pen)
        begin
            r.report    = (touch_level != 0);
            touch_level = '0;
        end
        else
        begin
            chan_mean[ch] = trimmed_mean(raw);
            if (ch != CH_Z2)
                return;
            xr = chan_mean[CH_X];
            yr = chan_mean[CH_Y];
            if (xr != 0 && yr != 0)
            begin
                follow = (touch_level == TOUCH_TOP);
                if (xr < cal_x_lo) cal_x_lo = sample_t'(xr);
                if (xr > cal_x_hi) cal_x_hi = sample_t'(xr);
                if (yr < cal_y_lo) cal_y_lo = sample_t'(yr);
                if (yr > cal_y_hi) cal_y_hi = sample_t'(yr);
                filt_x  = SMOOTH_X_W'(eased(filt_x,
                                            axis_target(cal_x_lo, cal_x_hi, xr, SCREEN_W),
                                            SMOOTH_X_MAX, follow));
                filt_y  = SMOOTH_Y_W'(eased(filt_y,
                                            axis_target(cal_y_lo, cal_y_hi, yr, SCREEN_H),
                                            SMOOTH_Y_MAX, follow));
                shown_x = filt_x[SMOOTH_X_W-1:FRAC_W];
                shown_y = filt_y[SMOOTH_Y_W-1:FRAC_W];
                r.pressure = PRESS_W'(pressure_est(xr, chan_mean[CH_Z1], chan_mean[CH_Z2]));
                if (touch_level < TOUCH_TOP)
                    touch_level = touch_level + 2'd1;
                else
                begin
                    r.report         = 1'b1;
                    r.report_pressed = 1'b1;
                end
            end
        end
        r.pos_x       = shown_x;
        r.pos_y       = shown_y;
        r.touch_state = touch_level;
        expected_cursors.push_back(r);
    endtask

    task automatic log_failure(input string what, input cursor_t want, input cursor_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t %s:", $realtime, what);
            $display("  want x=%0d y=%0d p=%0d st=%0d rep=%0b prs=%0b",
                     want.pos_x, want.pos_y, want.pressure, want.touch_state,
                     want.report, want.report_pressed);
            $display("  got  x=%0d y=%0d p=%0d st=%0d rep=%0b prs=%0b",
                     got.pos_x, got.pos_y, got.pressure, got.touch_state,
                     got.report, got.report_pressed);
        end
    endtask

    task automatic compare_result(input logic [OUT_DATA_W-1:0] data, input logic [1:0] flags);
        cursor_t got;
        cursor_t want;
        got.pos_x          = data[8:0];
        got.pos_y          = data[16:9];
        got.pressure       = data[32:17];
        got.touch_state    = data[34:33];
        got.report         = flags[0];
        got.report_pressed = flags[1];
        results_seen++;
        if (got.report)
            reports_seen++;
        if (got.report && got.report_pressed)
            pressed_seen++;
        if (expected_cursors.size() == 0)
        begin
            log_failure("result with no request behind it", '0, got);
            return;
        end
        want = expected_cursors.pop_front();
        if (got.pos_x != want.pos_x || got.pos_y != want.pos_y ||
            got.pressure != want.pressure || got.touch_state != want.touch_state ||
            got.report != want.report || got.report_pressed != want.report_pressed)
            log_failure("cursor mismatch", want, got);
    endtask

    // Register writes land first, then the request, then the result: a result
    // leaving in the same cycle always belongs to an older request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_defaults();
        end
        else
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata[59:0]);
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata, m_axis_tuser);
            pending = expected_cursors.size();
        end
    end

endmodule

@@ verif/tb_touch_sample_filter_calibrator.sv @@
// Top of the touch filter and calibrator testbench: clock, reset, register
// settings and request traffic, with the result checker beside the block.
// Depends on tsfc_pkg, touch_report_checker and the block itself.
`timescale 1ns / 1ps

module tb_touch_sample_filter_calibrator;
    import tsfc_pkg::*;

    localparam int SCREEN_W             = 320;
    localparam int SCREEN_H             = 240;
    localparam int NUM_SETTINGS         = 7;
    localparam int REQUESTS_PER_SETTING = 215;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample_a..sample_e, zero pad
    logic [2:0]            s_axis_tuser;   // pen_down, cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // pos_x, pos_y, pressure, touch_state, zero pad
    logic [1:0]            m_axis_tuser;   // report, report_pressed

    int fail_count;
    int pending;
    int results_seen;
    int reports_seen;
    int pressed_seen;
    int requests_sent;
    int cur_spread;
    int cur_lo;
    int cur_hi;
    bit calm;

    touch_sample_filter_calibrator #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    touch_report_checker #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) cursor_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .reports_seen  (reports_seen),
        .pressed_seen  (pressed_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: stalls come in random bursts, and none start while calm.
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results still outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input logic pen, input logic [1:0] ch, input logic [59:0] raw);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, raw};
        s_axis_tuser  <= {ch, pen};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        requests_sent++;
    endtask

    // Channel requests give no result, so a little slack follows the last one
    // before the registers are touched.
    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
    endtask

    task automatic program_filter(input int xmin, input int xmax, input int ymin,
                                  input int ymax, input int gain, input int spread,
                                  input int vlo, input int vhi);
        wait_for_drain();
        write_reg(REG_X_MIN, xmin);
        write_reg(REG_X_MAX, xmax);
        write_reg(REG_Y_MIN, ymin);
        write_reg(REG_Y_MAX, ymax);
        write_reg(REG_SMOOTH_GAIN, gain);
        write_reg(REG_SPREAD_LIMIT, spread);
        write_reg(REG_VALID_LOW, vlo);
        write_reg(REG_VALID_HIGH, vhi);
        @(negedge clk);
        cfg_we     <= 1'b0;
        cur_spread = spread;
        cur_lo     = vlo;
        cur_hi     = vhi;
    endtask

    function automatic sample_t near(input int base, input int jit);
        int v;
        v = base + int'($urandom_range(0, 2 * jit)) - jit;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // Five samples around one level; a spike replaces one of them with noise.
    function automatic logic [59:0] sample_burst(input int base, input int jit, input bit spike);
        logic [59:0] raw;
        for (int i = 0; i < 5; i++)
            raw[12*i +: 12] = near(base, jit);
        if (spike)
            raw[12 * $urandom_range(0, 4) +: 12] = 12'($urandom);
        return raw;
    endfunction

    function automatic int pick_level();
        if (cur_lo <= cur_hi)
            return $urandom_range(cur_lo, cur_hi);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_jitter();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, cur_spread / 2);
    endfunction

    task automatic send_scan(input int bx, input int by, input int bz1, input int bz2,
                             input int jit, input bit noisy);
        send_item(1'b1, CH_X,  sample_burst(bx,  jit, noisy && $urandom_range(0, 9) == 0));
        send_item(1'b1, CH_Y,  sample_burst(by,  jit, noisy && $urandom_range(0, 9) == 0));
        send_item(1'b1, CH_Z1, sample_burst(bz1, jit, noisy && $urandom_range(0, 9) == 0));
        send_item(1'b1, CH_Z2, sample_burst(bz2, jit, noisy && $urandom_range(0, 9) == 0));
    endtask

    task automatic send_noise(input logic pen);
        send_item(pen, 2'($urandom_range(0, 3)), 60'({$urandom, $urandom}));
    endtask

    // A stroke is a run of complete scans drifting slowly, usually closed by
    // a pen-up request, so the touch level climbs and the smoothing engages.
    task automatic send_stroke();
        int bx;
        int by;
        int bz1;
        int n;
        bx = pick_level();
        by = pick_level();
        n  = $urandom_range(1, 7);
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
                bz1 = cur_lo + $urandom_range(0, 8);
            else
                bz1 = pick_level();
            send_scan(bx, by, bz1, pick_level(), pick_jitter(), 1'b1);
            bx += int'($urandom_range(0, 40)) - 20;
            by += int'($urandom_range(0, 40)) - 20;
        end
        if ($urandom_range(0, 9) < 7)
            send_noise(1'b0);
    endtask

    task automatic send_broken_scan();
        repeat ($urandom_range(1, 3))
            send_item(1'b1, 2'($urandom_range(0, 3)),
                      sample_burst(pick_level(), pick_jitter(), $urandom_range(0, 3) == 0));
    endtask

    task automatic directed_part();
        // Pen-up while nothing is pressed: no report.
        send_item(1'b0, CH_Z2, {5{12'hFFF}});
        // Samples at both extremes fall outside the window, so x is zero and
        // the scan changes nothing.
        send_item(1'b1, CH_X, '0);
        send_item(1'b1, CH_Y, {5{12'hFFF}});
        send_item(1'b1, CH_Z1, sample_burst(400, 4, 1'b0));
        send_item(1'b1, CH_Z2, sample_burst(900, 4, 1'b0));
        send_scan(1000, 900, 300, 900, 6, 1'b0);
        // x under x_min and y over y_max widen the bounds; z1 is rejected, so
        // the pressure saturates.
        send_item(1'b1, CH_X, sample_burst(100, 3, 1'b0));
        send_item(1'b1, CH_Y, sample_burst(1990, 3, 1'b0));
        send_item(1'b1, CH_Z1, {5{12'hFFF}});
        send_item(1'b1, CH_Z2, sample_burst(500, 3, 1'b0));
        // z2 under z1 gives zero pressure; the touch level reaches the top.
        send_scan(2000, 50, 800, 400, 3, 1'b0);
        // First pressed report, with smoothing.
        send_scan(1200, 700, 200, 1800, 10, 1'b0);
        // Pen-up after a touch: released report.
        send_item(1'b0, CH_X, 60'({$urandom, $urandom}));
        // One sample too far from the mean rejects the channel.
        send_item(1'b1, CH_X, {12'd1100, 12'd1000, 12'd1000, 12'd1000, 12'd1000});
    endtask

    initial
    begin
        int quota;
        int pick;
        int lo_x;
        int lo_y;
        int guard;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_X_MIN;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        requests_sent = 0;
        cur_spread    = RST_SPREAD_LIMIT;
        cur_lo        = RST_VALID_LOW;
        cur_hi        = RST_VALID_HIGH;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_part();
        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            lo_x = $urandom_range(0, 2000);
            lo_y = $urandom_range(0, 2000);
            case (ph)
                1: program_filter(0, 4095, 0, 4095, 256, 4095, 0, 4095);
                2: program_filter(RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX, 0, 0,
                                  RST_VALID_LOW, RST_VALID_HIGH);
                // Reversed and collapsed bounds: positions scale to zero until
                // the scans pull the bounds apart.
                3: program_filter(3000, 100, 2000, 2000, 1, 64, 16, 4000);
                // Inverted window: every channel is rejected.
                4: program_filter(lo_x, lo_x + $urandom_range(1, 2095), lo_y,
                                  lo_y + $urandom_range(1, 2095), $urandom_range(0, 256),
                                  $urandom_range(0, 4095), 3000, 100);
                5, 6: program_filter(lo_x, lo_x + $urandom_range(1, 2095), lo_y,
                                     lo_y + $urandom_range(1, 2095), $urandom_range(0, 256),
                                     $urandom_range(8, 200), $urandom_range(0, 100),
                                     $urandom_range(3000, 4095));
                default: ;  // the first setting writes no registers
            endcase
            calm  = (ph == NUM_SETTINGS - 1);
            quota = requests_sent + REQUESTS_PER_SETTING;
            while (requests_sent < quota)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_stroke();
                else if (pick < 80)
                    send_noise(1'b0);
                else if (pick < 90)
                    send_broken_scan();
                else
                    send_noise($urandom_range(0, 1));
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (200) @(negedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived.", pending);
        $display("Drove %0d requests through %0d register settings, from clean strokes to noise.",
                 requests_sent, NUM_SETTINGS);
        $display("Compared %0d results, %0d cursor reports among them, %0d pressed.",
                 results_seen, reports_seen, pressed_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
